>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define SWMD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define SWMD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> src/swmd_pkg.sv
package swmd_pkg;

   localparam int WINDOW_MAX    = 64;
   localparam int SAMPLE_BITS   = 32;
   localparam int PTR_BITS      = $clog2(WINDOW_MAX);
   localparam int CNT_BITS      = PTR_BITS + 1;
   localparam int CFG_BITS      = 7;
   localparam int COST_BITS     = 37;
   localparam int ACC_BITS      = 38;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CAND_RD,
      ST_CAND_LD,
      ST_CMP_RD,
      ST_CMP_ACC,
      ST_TEST,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic write;
      logic init_j;
      logic sel_j;
      logic load_cand;
      logic cmp;
      logic next_j;
      logic sum_init;
      logic sum_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic i_last;
      logic is_median;
      logic out_busy;
   } status_type;

endpackage

>>> src/swmd_ram.sv
module swmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/swmd_ctrl.sv
module swmd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  swmd_pkg::status_type status,
   output swmd_pkg::cmd_type    cmd
);

   swmd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swmd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         swmd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write = 1'b1;
               state_in  = swmd_pkg::ST_CHECK;
            end
         end
         swmd_pkg::ST_CHECK: begin
            if (status.full) begin
               cmd.init_j = 1'b1;
               state_in   = swmd_pkg::ST_CAND_RD;
            end else begin
               state_in = swmd_pkg::ST_IDLE;
            end
         end
         swmd_pkg::ST_CAND_RD: begin
            cmd.sel_j = 1'b1;
            state_in  = swmd_pkg::ST_CAND_LD;
         end
         swmd_pkg::ST_CAND_LD: begin
            cmd.load_cand = 1'b1;
            state_in      = swmd_pkg::ST_CMP_RD;
         end
         swmd_pkg::ST_CMP_RD: begin
            state_in = swmd_pkg::ST_CMP_ACC;
         end
         swmd_pkg::ST_CMP_ACC: begin
            cmd.cmp  = 1'b1;
            state_in = status.i_last ? swmd_pkg::ST_TEST : swmd_pkg::ST_CMP_RD;
         end
         swmd_pkg::ST_TEST: begin
            // keep the candidate whose rank straddles the lower-median slot
            if (status.is_median) begin
               cmd.sum_init = 1'b1;
               state_in     = swmd_pkg::ST_SUM_RD;
            end else begin
               cmd.next_j = 1'b1;
               state_in   = swmd_pkg::ST_CAND_RD;
            end
         end
         swmd_pkg::ST_SUM_RD: begin
            state_in = swmd_pkg::ST_SUM_ACC;
         end
         swmd_pkg::ST_SUM_ACC: begin
            cmd.sum_step = 1'b1;
            state_in     = status.i_last ? swmd_pkg::ST_OUT : swmd_pkg::ST_SUM_RD;
         end
         swmd_pkg::ST_OUT: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = swmd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/swmd_dp.sv
module swmd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swmd_pkg::cmd_type                    cmd,
   output swmd_pkg::status_type                 status,
   input  logic [swmd_pkg::SAMPLE_BITS-1:0]     sample,
   input  logic                                 csr_valid,
   input  logic [swmd_pkg::CFG_BITS-1:0]        csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [swmd_pkg::COST_BITS-1:0]       rsp_cost
);

   localparam int PB = swmd_pkg::PTR_BITS;
   localparam int CB = swmd_pkg::CNT_BITS;
   localparam int SB = swmd_pkg::SAMPLE_BITS;
   localparam int AB = swmd_pkg::ACC_BITS;

   logic [PB-1:0]                     ptr_ff, ptr_in;
   logic [CB-1:0]                     fill_ff, fill_in;
   logic [swmd_pkg::CFG_BITS-1:0]     ksize_ff, ksize_in;
   logic [CB-1:0]                     j_ff, j_in, i_ff, i_in;
   logic [CB-1:0]                     lt_ff, lt_in, le_ff, le_in;
   logic [SB-1:0]                     cand_ff, cand_in, med_ff, med_in;
   logic [AB-1:0]                     acc_ff, acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swmd_pkg::COST_BITS-1:0]    rsp_cost_ff, rsp_cost_in;

   logic [CB-1:0]  keff, half, idx;
   logic [PB-1:0]  rd_addr;
   logic [SB-1:0]  rd_data;
   logic           is_lt, is_le;
   logic [SB:0]    diff, mag;

   swmd_ram #(
      .WIDTH(SB),
      .DEPTH(swmd_pkg::WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (ptr_ff),
      .wr_data (sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (ksize_ff == '0) begin
         keff = CB'(1);
      end else if (int'(ksize_ff) > swmd_pkg::WINDOW_MAX) begin
         keff = CB'(swmd_pkg::WINDOW_MAX);
      end else begin
         keff = CB'(ksize_ff);
      end
   end

   assign half    = CB'(({1'b0, keff} + (CB + 1)'(1)) >> 1);
   assign idx     = cmd.sel_j ? j_ff : i_ff;
   // newest sample sits one slot behind the write pointer
   assign rd_addr = ptr_ff - PB'(1) - idx[PB-1:0];

   assign is_lt = $signed(rd_data) < $signed(cand_ff);
   assign is_le = $signed(rd_data) <= $signed(cand_ff);
   assign diff  = {rd_data[SB-1], rd_data} - {med_ff[SB-1], med_ff};
   assign mag   = diff[SB] ? (SB + 1)'(-diff) : diff;

   always_comb begin
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      ksize_in     = ksize_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      cand_in      = cand_ff;
      med_in       = med_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cost_in  = rsp_cost_ff;

      if (csr_valid) begin
         ksize_in = csr_data;
      end
      if (cmd.write) begin
         ptr_in = ptr_ff + PB'(1);
         if (int'(fill_ff) < swmd_pkg::WINDOW_MAX) begin
            fill_in = fill_ff + CB'(1);
         end
      end
      if (cmd.init_j) begin
         j_in = '0;
      end
      if (cmd.next_j) begin
         j_in = j_ff + CB'(1);
      end
      if (cmd.load_cand) begin
         cand_in = rd_data;
         i_in    = '0;
         lt_in   = '0;
         le_in   = '0;
      end
      if (cmd.cmp) begin
         lt_in = lt_ff + CB'(is_lt);
         le_in = le_ff + CB'(is_le);
         i_in  = i_ff + CB'(1);
      end
      if (cmd.sum_init) begin
         med_in = cand_ff;
         i_in   = '0;
         acc_in = '0;
      end
      if (cmd.sum_step) begin
         acc_in = acc_ff + AB'(mag);
         i_in   = i_ff + CB'(1);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_cost_in  = acc_ff[swmd_pkg::COST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         fill_ff      <= '0;
         ksize_ff     <= swmd_pkg::CFG_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         ksize_ff     <= ksize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      i_ff        <= i_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      cand_ff     <= cand_in;
      med_ff      <= med_in;
      acc_ff      <= acc_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign status.full      = fill_ff >= keff;
   assign status.i_last    = i_ff == (keff - CB'(1));
   assign status.is_median = (lt_ff < half) && (le_ff >= half);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = rsp_cost_ff;

endmodule

>>> src/sliding_window_median_deviation.sv
// Sliding-window median absolute deviation. Each req transfer brings one signed
// sample; once K samples (csr window_size, 0 read as 1, above 64 read as 64)
// have arrived since reset, each sample yields one rsp transfer with the sum of
// |x - m| over the last K samples, m being their lower median. One sample is
// processed at a time: the samples live in a single-port-read RAM, and a
// controller walks candidates, ranking each against the whole window one RAM
// read at a time, then sums deviations the same way. While the window is not
// yet full an item ends at the fill check; otherwise the candidate walk stops
// as soon as the median is found. A finished result waits in its own register,
// so the next sample is taken while it is unread.
module sliding_window_median_deviation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [36:0] cost, [39:37] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_wdata    // [6:0] window_size
);

   swmd_pkg::cmd_type                  cmd;
   swmd_pkg::status_type               status;
   logic [swmd_pkg::COST_BITS-1:0]     cost;

   assign csr_ready = 1'b1;

   swmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   swmd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .sample    (req_tdata[swmd_pkg::SAMPLE_BITS-1:0]),
      .csr_valid (csr_valid),
      .csr_data  (csr_wdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_cost  (cost)
   );

   assign rsp_tdata = {{(swmd_pkg::RSP_DATA_BITS - swmd_pkg::COST_BITS){1'b0}}, cost};

endmodule

>>> src/swmd_checker.sv
`include "assert_macros.svh"

module swmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `SWMD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `SWMD_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)
   `SWMD_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `SWMD_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[39:37] == 3'b000)

endmodule

bind sliding_window_median_deviation swmd_checker u_swmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
